### rtl/lawqa_pkg.sv
// ----------------------------------------------------------------------------
// lawqa_pkg : shared constants for the lookahead window QP adjuster
// Field widths, register map, reset values and QP offset steps.
// ----------------------------------------------------------------------------
package lawqa_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // payload widths
    localparam int CX_W       = 16;
    localparam int QP_W       = 6;
    localparam int AQP_W      = 7;
    localparam int THR_W      = 16;
    localparam int FILL_OUT_W = 5;

    // APB port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = 2;

    localparam logic [RIDX_W-1:0] REG_BASE_QP  = 2'd0;
    localparam logic [RIDX_W-1:0] REG_HIGH_THR = 2'd1;
    localparam logic [RIDX_W-1:0] REG_LOW_THR  = 2'd2;

    localparam logic [QP_W-1:0]  BASE_QP_RST  = 6'd26;
    localparam logic [THR_W-1:0] HIGH_THR_RST = 16'd7680;
    localparam logic [THR_W-1:0] LOW_THR_RST  = 16'd1280;

    // offsets applied to base QP
    localparam logic [AQP_W-1:0] QP_CUT_PENALTY = 7'd2;
    localparam logic [AQP_W-1:0] QP_STEP        = 7'd1;

endpackage

### rtl/lawqa_if.sv
// ----------------------------------------------------------------------------
// lawqa_if : valid/ready channels of the lookahead window QP adjuster
// Frame request channel in, QP result channel out.
// ----------------------------------------------------------------------------
interface lawqa_in_if import lawqa_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CX_W-1:0] complexity;
    logic            scene_cut;

    modport source (output valid, output complexity, output scene_cut, input ready);
    modport sink   (input valid, input complexity, input scene_cut, output ready);
endinterface

interface lawqa_out_if import lawqa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [AQP_W-1:0]     adjusted_qp;
    logic                        window_has_cut;
    logic [FILL_OUT_W-1:0]       window_fill;

    modport source (output valid, output adjusted_qp, output window_has_cut,
                    output window_fill, input ready);
    modport sink   (input valid, input adjusted_qp, input window_has_cut,
                    input window_fill, output ready);
endinterface

### rtl/lawqa_cell.sv
// ----------------------------------------------------------------------------
// lawqa_cell : one slot of the frame window shift chain
// Holds one frame's complexity and cut flag; loads from its neighbour on shift.
// ----------------------------------------------------------------------------
module lawqa_cell import lawqa_pkg::*; (
    input  logic            clk,
    input  logic            shift,
    input  logic [CX_W-1:0] cx_in,
    input  logic            cut_in,
    output logic [CX_W-1:0] cx_out,
    output logic            cut_out
);

    logic [CX_W-1:0] cx_reg;
    logic            cut_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            cx_reg  <= cx_in;
            cut_reg <= cut_in;
        end
    end

    assign cx_out  = cx_reg;
    assign cut_out = cut_reg;

endmodule

### rtl/lookahead_window_qp_adjust.sv
// ----------------------------------------------------------------------------
// lookahead_window_qp_adjust : sliding-window QP offset from frame complexity
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    complexity[15:0], scene_cut
//   out_ch    out  valid/ready    adjusted_qp[6:0] (signed), window_has_cut,
//                                 window_fill[4:0]
//   apb       in   psel/penable   base_qp, high_threshold, low_threshold
//
// One frame request per cycle while out_ch takes results. The window state
// updates at accept; the threshold products and QP offset are then
// registered into the output stage, which holds while out_ch stalls.
// The window is a chain of DEPTH cells; every accept shifts it by one.
// Reset clears the window sums, fill count and pipeline valids; the cell
// contents are not reset and are only read once the window is full.
// in_ch.ready drops only while the output register holds an untaken result
// and a second result waits behind it.
// ----------------------------------------------------------------------------
module lookahead_window_qp_adjust import lawqa_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // streams
    lawqa_in_if.sink            in_ch,
    lawqa_out_if.source         out_ch
);

    localparam int FW = $clog2(DEPTH + 1);   // fill and cut count width
    localparam int SW = CX_W + FW;           // window sum width
    localparam logic [FW-1:0] FULL = FW'(DEPTH);

    // ---------------- configuration registers ----------------
    logic [QP_W-1:0]   base_qp_reg;
    logic [THR_W-1:0]  high_thr_reg;
    logic [THR_W-1:0]  low_thr_reg;
    logic [RIDX_W-1:0] reg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[RIDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_qp_reg  <= BASE_QP_RST;
            high_thr_reg <= HIGH_THR_RST;
            low_thr_reg  <= LOW_THR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BASE_QP:  base_qp_reg  <= pwdata[QP_W-1:0];
                REG_HIGH_THR: high_thr_reg <= pwdata[THR_W-1:0];
                REG_LOW_THR:  low_thr_reg  <= pwdata[THR_W-1:0];
                default: ;    // unmapped slot, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BASE_QP:  prdata = PDATA_W'(base_qp_reg);
            REG_HIGH_THR: prdata = PDATA_W'(high_thr_reg);
            REG_LOW_THR:  prdata = PDATA_W'(low_thr_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_acc, out_load;

    assign out_load    = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || out_load;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // ---------------- window cell chain ----------------
    // cell 0 takes the new frame; the last cell holds the oldest once full
    logic [CX_W-1:0] cx_chain  [DEPTH];
    logic            cut_chain [DEPTH];
    logic            cut_eff;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            lawqa_cell u_cell (
                .clk     (clk),
                .shift   (in_acc),
                .cx_in   (in_ch.complexity),
                .cut_in  (cut_eff),
                .cx_out  (cx_chain[i]),
                .cut_out (cut_chain[i])
            );
        end
        else
        begin : g_body
            lawqa_cell u_cell (
                .clk     (clk),
                .shift   (in_acc),
                .cx_in   (cx_chain[i-1]),
                .cut_in  (cut_chain[i-1]),
                .cx_out  (cx_chain[i]),
                .cut_out (cut_chain[i])
            );
        end
    end

    // ---------------- running window totals ----------------
    logic [SW-1:0] sum_reg, sum_next;
    logic [FW-1:0] cut_total_reg, cut_total_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] fill_kept;
    logic          full;
    logic [CX_W-1:0] drop_cx;
    logic          drop_cut;

    always_comb
    begin
        full      = (fill_reg == FULL);
        drop_cx   = full ? cx_chain[DEPTH-1] : '0;
        drop_cut  = full && cut_chain[DEPTH-1];
        fill_kept = full ? fill_reg - FW'(1) : fill_reg;
        // a frame entering an empty window never counts as a cut
        cut_eff   = in_ch.scene_cut && (fill_kept != '0);

        sum_next       = sum_reg - SW'(drop_cx) + SW'(in_ch.complexity);
        cut_total_next = cut_total_reg - FW'(drop_cut) + FW'(cut_eff);
        fill_next      = fill_kept + FW'(1);

        s1_valid_next  = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
        out_valid_next = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cut_total_reg <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                sum_reg       <= sum_next;
                cut_total_reg <= cut_total_next;
                fill_reg      <= fill_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- QP offset stage ----------------
    // mean tests done as sum vs threshold * fill, no divide
    logic [SW-1:0]         hi_lim, lo_lim;
    logic                  above, below, has_cut;
    logic [AQP_W-1:0]      qp_calc;
    logic [FW+FILL_OUT_W-1:0] fill_ext;

    always_comb
    begin
        hi_lim  = SW'(high_thr_reg) * SW'(fill_reg);
        lo_lim  = SW'(low_thr_reg) * SW'(fill_reg);
        above   = sum_reg > hi_lim;
        below   = sum_reg < lo_lim;
        has_cut = (cut_total_reg != '0);

        qp_calc = AQP_W'(base_qp_reg);
        if (has_cut)
            qp_calc = qp_calc - QP_CUT_PENALTY;
        if (above)
            qp_calc = qp_calc + QP_STEP;
        else if (below)
            qp_calc = qp_calc - QP_STEP;

        fill_ext = {{FILL_OUT_W{1'b0}}, fill_reg};
    end

    logic [AQP_W-1:0]      qp_reg;
    logic                  has_cut_reg;
    logic [FILL_OUT_W-1:0] fill_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            qp_reg       <= qp_calc;
            has_cut_reg  <= has_cut;
            fill_out_reg <= fill_ext[FILL_OUT_W-1:0];
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.adjusted_qp    = qp_reg;
    assign out_ch.window_has_cut = has_cut_reg;
    assign out_ch.window_fill    = fill_out_reg;

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL)
        else $error("window fill beyond depth");

    a_cut_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cut_total_reg <= fill_reg)
        else $error("cut count exceeds window fill");

    a_first_no_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && fill_reg == '0) |=> (cut_total_reg == '0))
        else $error("cut counted on empty window");

    a_acc_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted request lost before QP stage");

    a_pending_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (fill_reg != '0))
        else $error("pending result with empty window");

endmodule
